/* hdl/rwh_pkg.sv */
// shared types, event codes and tag constants for the riff/wave header parser
package rwh_pkg;

  localparam int FMT_W = 128;
  localparam int DATA_W = 64;

  localparam logic [2:0] EV_FORMAT  = 3'd0;
  localparam logic [2:0] EV_DATA    = 3'd1;
  localparam logic [2:0] EV_END     = 3'd2;
  localparam logic [2:0] EV_NORIFF  = 3'd3;
  localparam logic [2:0] EV_NOWAVE  = 3'd4;
  localparam logic [2:0] EV_SMALL   = 3'd5;
  localparam logic [2:0] EV_UNKNOWN = 3'd6;
  localparam logic [2:0] EV_TRUNC   = 3'd7;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

  // one queue entry: the results caused by one accepted item
  typedef struct packed {
    logic             ev0_v;
    logic [2:0]       ev0_kind;
    logic             ev1_v;
    logic [2:0]       ev1_kind;
    logic [FMT_W-1:0] payload;
  } rwh_entry_t;

  // leading bytes of a tag seen after byte k of it
  function automatic logic [31:0] tag_prefix(input logic [31:0] tag, input logic [1:0] k);
    logic [31:0] p;
    case (k)
      2'd0:    p = {24'd0, tag[31:24]};
      2'd1:    p = {16'd0, tag[31:16]};
      2'd2:    p = {8'd0, tag[31:8]};
      default: p = tag;
    endcase
    return p;
  endfunction

endpackage

/* hdl/rwh_front.sv */
// front end: byte parser state machine that classifies each item into queue entries
module rwh_front
  import rwh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  input  logic       in_end_of_stream,
  input  logic       q_full,
  output logic       q_push,
  output rwh_entry_t q_entry
);

  localparam logic [3:0] PH_RIFF     = 4'd0;
  localparam logic [3:0] PH_FSIZE    = 4'd1;
  localparam logic [3:0] PH_WAVE     = 4'd2;
  localparam logic [3:0] PH_ID       = 4'd3;
  localparam logic [3:0] PH_FMTSIZE  = 4'd4;
  localparam logic [3:0] PH_FMT      = 4'd5;
  localparam logic [3:0] PH_FMTSKIP  = 4'd6;
  localparam logic [3:0] PH_DATASIZE = 4'd7;
  localparam logic [3:0] PH_DATA     = 4'd8;
  localparam logic [3:0] PH_ERR      = 4'd9;

  logic [3:0]       phase_r, phase_nxt;
  logic [3:0]       idx_r, idx_nxt;
  logic [31:0]      shift_r, shift_nxt;
  logic [32:0]      skip_r, skip_nxt;
  logic [31:0]      pos_r, pos_nxt;
  logic [FMT_W-1:0] fmt_r, fmt_nxt;
  logic             err_r, err_nxt;

  logic             accept;
  logic [1:0]       k2;
  logic [31:0]      tag_sh;
  logic [31:0]      size_acc;
  logic             ev0_v, ev1_v;
  logic [2:0]       ev0_kind, ev1_kind;
  logic [31:0]      data_size;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign k2       = idx_r[1:0];
  assign tag_sh   = {shift_r[23:0], in_byte_in};
  assign size_acc = shift_r | ({24'd0, in_byte_in} << {k2, 3'b000});

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    shift_nxt = shift_r;
    skip_nxt  = skip_r;
    fmt_nxt   = fmt_r;
    err_nxt   = err_r;
    pos_nxt   = (pos_r == 32'hffff_ffff) ? pos_r : pos_r + 32'd1;
    ev0_v     = 1'b0;
    ev0_kind  = EV_FORMAT;
    ev1_v     = 1'b0;
    ev1_kind  = EV_END;
    data_size = size_acc;

    case (phase_r)
      PH_RIFF, PH_WAVE: begin
        if (tag_sh != tag_prefix((phase_r == PH_RIFF) ? TAG_RIFF : TAG_WAVE, k2)) begin
          phase_nxt = PH_ERR;
          err_nxt   = 1'b1;
          shift_nxt = {29'd0, (phase_r == PH_RIFF) ? EV_NORIFF : EV_NOWAVE};
          idx_nxt   = 4'd0;
          ev0_v     = 1'b1;
          ev0_kind  = (phase_r == PH_RIFF) ? EV_NORIFF : EV_NOWAVE;
        end else if (k2 == 2'd3) begin
          phase_nxt = (phase_r == PH_RIFF) ? PH_FSIZE : PH_ID;
          idx_nxt   = 4'd0;
          shift_nxt = 32'd0;
        end else begin
          shift_nxt = tag_sh;
          idx_nxt   = {2'b00, k2} + 4'd1;
        end
      end
      PH_FSIZE: begin
        if (k2 == 2'd3) begin
          phase_nxt = PH_WAVE;
          idx_nxt   = 4'd0;
          shift_nxt = 32'd0;
        end else begin
          shift_nxt = size_acc;
          idx_nxt   = {2'b00, k2} + 4'd1;
        end
      end
      PH_ID: begin
        if (tag_sh != tag_prefix(TAG_FMT, k2) && tag_sh != tag_prefix(TAG_DATA, k2)) begin
          phase_nxt = PH_ERR;
          err_nxt   = 1'b1;
          shift_nxt = {29'd0, EV_UNKNOWN};
          idx_nxt   = 4'd0;
          ev0_v     = 1'b1;
          ev0_kind  = EV_UNKNOWN;
        end else if (k2 == 2'd3) begin
          phase_nxt = (tag_sh == TAG_FMT) ? PH_FMTSIZE : PH_DATASIZE;
          idx_nxt   = 4'd0;
          shift_nxt = 32'd0;
        end else begin
          shift_nxt = tag_sh;
          idx_nxt   = {2'b00, k2} + 4'd1;
        end
      end
      PH_FMTSIZE: begin
        if (k2 == 2'd3) begin
          idx_nxt   = 4'd0;
          shift_nxt = 32'd0;
          if (size_acc < FMT_MIN_SIZE) begin
            phase_nxt = PH_ERR;
            err_nxt   = 1'b1;
            shift_nxt = {29'd0, EV_SMALL};
            ev0_v     = 1'b1;
            ev0_kind  = EV_SMALL;
          end else begin
            skip_nxt  = {1'b0, size_acc} + {32'd0, size_acc[0]} - {1'b0, FMT_MIN_SIZE};
            fmt_nxt   = '0;
            phase_nxt = PH_FMT;
          end
        end else begin
          shift_nxt = size_acc;
          idx_nxt   = {2'b00, k2} + 4'd1;
        end
      end
      PH_FMT: begin
        fmt_nxt[{idx_r, 3'b000} +: 8] = in_byte_in;
        if (idx_r == 4'd15) begin
          idx_nxt = 4'd0;
          if (skip_r == 33'd0) begin
            phase_nxt = PH_ID;
            ev0_v     = 1'b1;
            ev0_kind  = EV_FORMAT;
          end else begin
            phase_nxt = PH_FMTSKIP;
          end
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      PH_FMTSKIP: begin
        if (skip_r != 33'd0) skip_nxt = skip_r - 33'd1;
        if (skip_r == 33'd0 || skip_r == 33'd1) begin
          phase_nxt = PH_ID;
          ev0_v     = 1'b1;
          ev0_kind  = EV_FORMAT;
        end
      end
      PH_DATASIZE: begin
        if (k2 == 2'd3) begin
          idx_nxt   = 4'd0;
          shift_nxt = 32'd0;
          skip_nxt  = {1'b0, size_acc} + {32'd0, size_acc[0]};
          phase_nxt = (size_acc == 32'd0) ? PH_ID : PH_DATA;
          ev0_v     = 1'b1;
          ev0_kind  = EV_DATA;
        end else begin
          shift_nxt = size_acc;
          idx_nxt   = {2'b00, k2} + 4'd1;
        end
      end
      PH_DATA: begin
        if (skip_r != 33'd0) skip_nxt = skip_r - 33'd1;
        if (skip_r == 33'd0 || skip_r == 33'd1) phase_nxt = PH_ID;
      end
      default: begin
      end
    endcase

    // end of stream: report the outcome, then back to the reset state
    if (in_end_of_stream) begin
      if (err_r) begin
        ev1_v    = 1'b1;
        ev1_kind = shift_r[2:0];
      end else if (!err_nxt) begin
        ev1_v    = 1'b1;
        ev1_kind = (phase_nxt == PH_DATA || (phase_nxt == PH_ID && idx_nxt == 4'd0))
                   ? EV_END : EV_TRUNC;
      end
      phase_nxt = PH_RIFF;
      idx_nxt   = 4'd0;
      shift_nxt = 32'd0;
      skip_nxt  = 33'd0;
      pos_nxt   = 32'd0;
      fmt_nxt   = '0;
      err_nxt   = 1'b0;
    end
  end

  assign q_push           = accept && (ev0_v || ev1_v);
  assign q_entry.ev0_v    = ev0_v;
  assign q_entry.ev0_kind = ev0_kind;
  assign q_entry.ev1_v    = ev1_v;
  assign q_entry.ev1_kind = ev1_kind;
  // data result carries position after this byte and the size field; a format
  // result on the last fmt byte takes that byte straight into the top lane
  assign q_entry.payload  = (ev0_kind == EV_DATA)
                            ? {{(FMT_W-DATA_W){1'b0}},
                               (pos_r == 32'hffff_ffff) ? pos_r : pos_r + 32'd1, data_size}
                            : ((phase_r == PH_FMT) ? {in_byte_in, fmt_r[FMT_W-9:0]} : fmt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      idx_r   <= 4'd0;
      shift_r <= 32'd0;
      skip_r  <= 33'd0;
      pos_r   <= 32'd0;
      fmt_r   <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      shift_r <= shift_nxt;
      skip_r  <= skip_nxt;
      pos_r   <= pos_nxt;
      fmt_r   <= fmt_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

/* hdl/rwh_queue.sv */
// small entry queue between the parser front end and the result back end
module rwh_queue
  import rwh_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rwh_entry_t push_entry,
  input  logic       pop,
  output rwh_entry_t head,
  output logic       full,
  output logic       empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rwh_entry_t       q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !full) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1) else $error("count lost a push");
`endif

endmodule

/* hdl/rwh_back.sv */
// back end: splits queue entries into result items behind an output register
module rwh_back
  import rwh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rwh_entry_t  head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [15:0] out_compression_code,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [31:0] out_byte_rate,
  output logic [15:0] out_frame_align,
  output logic [15:0] out_sample_bits,
  output logic [31:0] out_payload_offset,
  output logic [31:0] out_payload_size,
  output logic        out_last_of_run
);

  logic             out_valid_r;
  logic             second_r;
  logic [2:0]       kind_r;
  logic             last_r;
  logic [FMT_W-1:0] pay_r;

  logic       load, take, first, last_sel;
  logic [2:0] kind_sel;

  assign load     = !out_valid_r || out_ready;
  assign take     = load && !q_empty;
  assign first    = head.ev0_v && !second_r;
  assign kind_sel = first ? head.ev0_kind : head.ev1_kind;
  assign last_sel = !(first && head.ev1_v);
  assign q_pop    = take && last_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else if (load) begin
      out_valid_r <= take;
      if (take) second_r <= !last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= kind_sel;
      last_r <= last_sel;
      pay_r  <= head.payload;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = kind_r;
  assign out_last_of_run = last_r;

  always_comb begin
    out_compression_code = 16'd0;
    out_channel_count    = 16'd0;
    out_sample_rate      = 32'd0;
    out_byte_rate        = 32'd0;
    out_frame_align      = 16'd0;
    out_sample_bits      = 16'd0;
    out_payload_offset   = 32'd0;
    out_payload_size     = 32'd0;
    if (kind_r == EV_FORMAT) begin
      out_compression_code = pay_r[15:0];
      out_channel_count    = pay_r[31:16];
      out_sample_rate      = pay_r[63:32];
      out_byte_rate        = pay_r[95:64];
      out_frame_align      = pay_r[111:96];
      out_sample_bits      = pay_r[127:112];
    end else if (kind_r == EV_DATA) begin
      out_payload_offset = pay_r[63:32];
      out_payload_size   = pay_r[31:0];
    end
  end

endmodule

/* hdl/riff_wave_header_parser.sv */
// top level of the riff/wave header parser: front end, entry queue, back end
//
// usage
//   input channel: one file byte per item (in_byte_in), with in_end_of_stream
//     marking the last byte of a file; taken when in_valid and in_ready are high
//   result channel: format, data-found, outcome and error items on out_*;
//     out_last_of_run marks the final item caused by one input byte
// throughput
//   one byte per cycle while the queue is not full; a byte never causes
//   more than two result items, and the back end drives one item per cycle
//   while out_ready is high, popping an entry only after its last item
// result path
//   a result passes through the queue and then the output register before
//   it shows on out_valid
// stalls
//   the front end parses into a QUEUE_DEPTH entry queue; in_ready drops only
//   when that queue is full, so a stalled receiver is absorbed until it fills
// reset
//   rst_n clears the parse state, the queue and the output register; the block
//   is ready for a new file as soon as reset is released
module riff_wave_header_parser
  import rwh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [15:0] out_compression_code,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [31:0] out_byte_rate,
  output logic [15:0] out_frame_align,
  output logic [15:0] out_sample_bits,
  output logic [31:0] out_payload_offset,
  output logic [31:0] out_payload_size,
  output logic        out_last_of_run
);

  // queue handshake between the two halves
  logic       q_full, q_empty, q_push, q_pop;
  rwh_entry_t q_in, q_head;

  // parser state machine, one byte per accepted item
  rwh_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_in)
  );

  // each entry holds every result of one byte
  rwh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // splits entries into items and holds the output register
  rwh_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (q_head),
    .q_empty              (q_empty),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_event_kind       (out_event_kind),
    .out_compression_code (out_compression_code),
    .out_channel_count    (out_channel_count),
    .out_sample_rate      (out_sample_rate),
    .out_byte_rate        (out_byte_rate),
    .out_frame_align      (out_frame_align),
    .out_sample_bits      (out_sample_bits),
    .out_payload_offset   (out_payload_offset),
    .out_payload_size     (out_payload_size),
    .out_last_of_run      (out_last_of_run)
  );

endmodule
